// File: sv/tme_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tme_pkg
// Shared types and constants of the tape machine execute unit: command
// characters, status codes, register indexes and memory request bundles.
// ---------------------------------------------------------------------------
package tme_pkg;

    // Command characters (ASCII).
    localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CH_IN    = 8'h2C;  // ','
    localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_QUIT  = 8'h71;  // 'q'

    typedef logic [2:0] status_t;

    localparam status_t ST_OK    = 3'd0;
    localparam status_t ST_OVER  = 3'd1;
    localparam status_t ST_UNDER = 3'd2;
    localparam status_t ST_QUIT  = 3'd3;
    localparam status_t ST_FULL  = 3'd4;
    localparam status_t ST_EMPTY = 3'd5;
    localparam status_t ST_END   = 3'd6;

    // Field and register widths fixed by the interface.
    localparam int CFG_DATA_W  = 16;
    localparam int TAPE_SIZE_W = 13;
    localparam int PLEN_W      = 16;
    localparam int NEXT_POS_W  = 16;

    // Configuration register indexes.
    localparam logic REG_TAPE_SIZE      = 1'b0;
    localparam logic REG_PROGRAM_LENGTH = 1'b1;

    localparam logic [TAPE_SIZE_W-1:0] TAPE_SIZE_RESET = 13'd4096;
    localparam logic [PLEN_W-1:0]      PLEN_RESET      = 16'd0;

    // Read and write strobes of one memory for one cycle.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_req_t;

endpackage
`default_nettype wire

// File: sv/tme_tape.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tme_tape
// Tape cell memory with registered read, write-to-read bypass and
// a clearing sweep after reset.
// ---------------------------------------------------------------------------
module tme_tape
    import tme_pkg::*;
#(
    parameter int CELLS = 4096,
    parameter int AW    = $clog2(CELLS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire mem_req_t      req,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    output logic [7:0]         rd_data,
    output logic               busy
);

    logic [7:0]    mem [CELLS];
    logic [7:0]    rd_reg;
    logic          byp_reg;
    logic [7:0]    byp_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(CELLS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (req.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // A write to the address being read lands in the same cycle, so the
        // new value is carried alongside the stale array output.
        if (req.rd_en) begin
            rd_reg       <= mem[rd_addr];
            byp_reg      <= req.wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;
    assign busy    = clr_busy_reg;

endmodule
`default_nettype wire

// File: sv/tme_stack.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tme_stack
// Loop position stack memory with registered read and write-to-read bypass.
// ---------------------------------------------------------------------------
module tme_stack
    import tme_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int DW    = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire mem_req_t      req,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    output logic [DW-1:0]      rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_reg;
    logic          byp_reg;
    logic [DW-1:0] byp_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_reg       <= mem[rd_addr];
            byp_reg      <= req.wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule
`default_nettype wire

// File: sv/tape_machine_execute_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tape_machine_execute_unit
// Executes one tape machine command per request: tape cell update, head
// move, loop stack push or pop, and the next program position and status.
// ---------------------------------------------------------------------------
// A request is registered into the execute stage when accepted, and its result
// into the output registers once they are free. Throughput: one request per
// cycle unless the output stalls or the tape is clearing; the next request's
// tape and stack reads are addressed from the state execute is writing back.
// Reset: synchronous; the tape memory is then cleared one cell a cycle with
// s_ready low. Configuration writes are taken as ever.
module tape_machine_execute_unit
    import tme_pkg::*;
#(
    parameter int TAPE_CELLS    = 4096,
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_op_char,
    input  wire logic [7:0]            s_in_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [NEXT_POS_W-1:0]      m_next_position,
    output logic                       m_out_valid,
    output logic [7:0]                 m_out_byte,
    output logic [2:0]                 m_status,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int HW  = $clog2(TAPE_CELLS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int PB  = POSITION_BITS;
    localparam int LW  = ((HW > TAPE_SIZE_W) ? HW : TAPE_SIZE_W) + 1;
    localparam int CW  = (PB > PLEN_W) ? PB : PLEN_W;

    logic [TAPE_SIZE_W-1:0] tape_size_reg;
    logic [PLEN_W-1:0]      prog_len_reg;
    logic [HW-1:0]          head_reg, head_next, head_c;
    logic [PB-1:0]          pos_reg, pos_next, pos_c, pos_inc;
    logic [DW-1:0]          depth_reg, depth_next, depth_c, depth_dec;

    logic                   ex_valid_reg;
    logic [7:0]             ex_op_reg;
    logic [7:0]             ex_byte_reg;

    logic                   m_valid_reg;
    logic [NEXT_POS_W-1:0]  m_pos_reg;
    logic                   m_ov_reg;
    logic [7:0]             m_ob_reg;
    status_t                m_status_reg;

    logic                   tape_busy;
    logic [7:0]             tape_rd;
    logic [PB-1:0]          stack_top;
    logic                   ex_fire, accept, at_end;
    logic [LW-1:0]          limit, size_ext, head_inc;
    logic [CW-1:0]          next_pos_ext;
    status_t                status_c;
    logic                   ov_c;
    logic [7:0]             ob_c;
    logic                   tape_we_c, stk_we_c;
    logic [7:0]             tape_wd_c;
    mem_req_t               tape_req, stk_req;

    assign ex_fire = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !tape_busy && (!ex_valid_reg || ex_fire);
    assign accept  = s_valid && s_ready;

    assign size_ext = LW'(tape_size_reg);
    assign limit    = (size_ext > LW'(TAPE_CELLS)) ? LW'(TAPE_CELLS) : size_ext;
    assign head_inc = LW'(head_reg) + LW'(1);
    assign at_end   = CW'(pos_reg) >= CW'(prog_len_reg);
    assign pos_inc  = pos_reg + 1'b1;

    always_comb begin
        head_c    = head_reg;
        pos_c     = pos_inc;
        depth_c   = depth_reg;
        status_c  = ST_OK;
        ov_c      = 1'b0;
        ob_c      = '0;
        tape_we_c = 1'b0;
        tape_wd_c = tape_rd;
        stk_we_c  = 1'b0;
        if (at_end) begin
            status_c = ST_END;
            pos_c    = pos_reg;
        end else begin
            unique case (ex_op_reg)
                CH_INC: begin
                    tape_we_c = 1'b1;
                    tape_wd_c = tape_rd + 8'd1;
                end
                CH_DEC: begin
                    tape_we_c = 1'b1;
                    tape_wd_c = tape_rd - 8'd1;
                end
                CH_RIGHT: begin
                    if (head_inc >= limit) begin
                        status_c = ST_OVER;
                        pos_c    = pos_reg;
                    end else begin
                        head_c = head_reg + 1'b1;
                    end
                end
                CH_LEFT: begin
                    if (head_reg == '0) begin
                        status_c = ST_UNDER;
                        pos_c    = pos_reg;
                    end else begin
                        head_c = head_reg - 1'b1;
                    end
                end
                CH_IN: begin
                    tape_we_c = 1'b1;
                    tape_wd_c = ex_byte_reg;
                end
                CH_OUT: begin
                    ov_c = 1'b1;
                    ob_c = tape_rd;
                end
                CH_OPEN: begin
                    if (depth_reg == DW'(STACK_DEPTH)) begin
                        status_c = ST_FULL;
                        pos_c    = pos_reg;
                    end else begin
                        stk_we_c = 1'b1;
                        depth_c  = depth_reg + 1'b1;
                    end
                end
                CH_CLOSE: begin
                    if (depth_reg == '0) begin
                        status_c = ST_EMPTY;
                        pos_c    = pos_reg;
                    end else if (tape_rd == 8'd0) begin
                        depth_c = depth_reg - 1'b1;
                    end else begin
                        // The stack entry stays; execution resumes after '['.
                        pos_c = stack_top + 1'b1;
                    end
                end
                CH_QUIT: begin
                    status_c = ST_QUIT;
                end
                default: begin
                end
            endcase
        end
    end

    assign head_next    = ex_fire ? head_c : head_reg;
    assign pos_next     = ex_fire ? pos_c : pos_reg;
    assign depth_next   = ex_fire ? depth_c : depth_reg;
    assign depth_dec    = depth_next - 1'b1;
    assign next_pos_ext = CW'(pos_c);

    assign tape_req.rd_en = accept;
    assign tape_req.wr_en = ex_fire && tape_we_c;
    assign stk_req.rd_en  = accept;
    assign stk_req.wr_en  = ex_fire && stk_we_c;

    // The next request's reads are addressed from the state being written
    // back this cycle, so back-to-back commands see each other's effects.
    tme_tape #(
        .CELLS (TAPE_CELLS),
        .AW    (HW)
    ) u_tape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tape_req),
        .rd_addr (head_next),
        .wr_addr (head_reg),
        .wr_data (tape_wd_c),
        .rd_data (tape_rd),
        .busy    (tape_busy)
    );

    tme_stack #(
        .DEPTH (STACK_DEPTH),
        .DW    (PB),
        .AW    (SAW)
    ) u_stack (
        .aclk    (aclk),
        .req     (stk_req),
        .rd_addr (depth_dec[SAW-1:0]),
        .wr_addr (depth_reg[SAW-1:0]),
        .wr_data (pos_reg),
        .rd_data (stack_top)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tape_size_reg <= TAPE_SIZE_RESET;
            prog_len_reg  <= PLEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TAPE_SIZE:      tape_size_reg <= cfg_wdata[TAPE_SIZE_W-1:0];
                REG_PROGRAM_LENGTH: prog_len_reg  <= cfg_wdata[PLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            pos_reg      <= '0;
            depth_reg    <= '0;
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            pos_reg   <= pos_next;
            depth_reg <= depth_next;
            if (accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ex_op_reg   <= s_op_char;
            ex_byte_reg <= s_in_byte;
        end
        if (ex_fire) begin
            m_pos_reg    <= next_pos_ext[NEXT_POS_W-1:0];
            m_ov_reg     <= ov_c;
            m_ob_reg     <= ob_c;
            m_status_reg <= status_c;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_next_position = m_pos_reg;
    assign m_out_valid     = m_ov_reg;
    assign m_out_byte      = m_ob_reg;
    assign m_status        = m_status_reg;

    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) tape_busy |-> !s_ready
    ) else $error("request accepted during tape clearing");

    a_depth_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn) depth_reg <= DW'(STACK_DEPTH)
    ) else $error("loop depth beyond stack size");

    a_head_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn) LW'(head_reg) < LW'(TAPE_CELLS)
    ) else $error("head beyond tape");

    a_push_counts: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (ex_fire && stk_we_c) |=> (depth_reg == $past(depth_reg) + 1'b1)
    ) else $error("push did not advance loop depth");

endmodule
`default_nettype wire
